/* hdl/cds_pkg.sv */
// cds_pkg: widths, fixed-point constants and helpers of the level smoother
// no dependencies; used by the channel interfaces and the top level
package cds_pkg;

  localparam int FRAC_BITS = 16;

  // field widths
  localparam int LVL_W = FRAC_BITS + 1;
  localparam int DT_W  = FRAC_BITS;
  localparam int ST_W  = 20;
  localparam int THR_W = FRAC_BITS + 1;
  localparam int CFG_W = 20;

  // datapath widths
  localparam int VAL_W  = 52;
  localparam int MAG_W  = VAL_W - 1;
  localparam int MR_W   = 32;
  localparam int PROD_W = MAG_W + MR_W;
  localparam int DIV_W  = 2 * FRAC_BITS + 2;
  localparam int DEN_W  = 41;
  localparam int VEL_W  = 32;

  // constants in fixed point
  localparam logic [LVL_W-1:0] ONE   = LVL_W'(1) << FRAC_BITS;
  localparam logic [ST_W-1:0]  EPS_T = ST_W'(((1 << FRAC_BITS) + 5000) / 10000);
  localparam logic [MR_W-1:0]  C048  = MR_W'((48 * (1 << FRAC_BITS) + 50) / 100);
  localparam logic [MR_W-1:0]  C0235 = MR_W'((235 * (1 << FRAC_BITS) + 500) / 1000);
  localparam logic [32:0]      XCAP  = 33'(256) << FRAC_BITS;

  // register indexes
  localparam logic REG_SMOOTH_TIME   = 1'b0;
  localparam logic REG_LOW_THRESHOLD = 1'b1;

  typedef logic signed [VAL_W-1:0] val_t;

  // magnitude of a signed intermediate
  function automatic logic [MAG_W-1:0] mag(input val_t v);
    val_t a;
    a = v[VAL_W-1] ? -v : v;
    return a[MAG_W-1:0];
  endfunction

endpackage

/* hdl/cds_if.sv */
// cds_if: valid/ready channels for ticks and smoothed results
// depends on cds_pkg
interface cds_tick_if;
  import cds_pkg::*;
  logic             valid;
  logic             ready;
  logic [LVL_W-1:0] level;
  logic [DT_W-1:0]  tick_time;
  modport source (output valid, level, tick_time, input ready);
  modport sink (input valid, level, tick_time, output ready);
endinterface

interface cds_result_if;
  import cds_pkg::*;
  logic             valid;
  logic             ready;
  logic [LVL_W-1:0] smoothed_level;
  logic             low_flag;
  logic             low_changed;
  modport source (output valid, smoothed_level, low_flag, low_changed, input ready);
  modport sink (input valid, smoothed_level, low_flag, low_changed, output ready);
endinterface

/* hdl/critically_damped_smoother.sv */
// critically_damped_smoother: spring smoother with low-level flag, Q16
// zero tick time or zero smoothing time go straight from idle to the final state;
// otherwise the bit-serial multiply/divide unit runs (up to two 34-bit-quotient
// divisions and ten shift-add multiplies that end once the multiplier runs out)
// throughput: one request at a time; the next is taken while a result waits
// reset (rst, synchronous): registers to defaults, value/velocity/flag cleared
module critically_damped_smoother
  import cds_pkg::*;
(
  input  logic            clk,
  input  logic            rst,
  input  logic            cfg_write_en,
  input  logic            cfg_index,
  input  logic [CFG_W-1:0] cfg_data,
  cds_tick_if.sink        tick,
  cds_result_if.source    smooth
);

  localparam logic [3:0] S_IDLE  = 4'd0;
  localparam logic [3:0] S_OMEGA = 4'd1;
  localparam logic [3:0] S_X     = 4'd2;
  localparam logic [3:0] S_X2    = 4'd3;
  localparam logic [3:0] S_X3    = 4'd4;
  localparam logic [3:0] S_C1    = 4'd5;
  localparam logic [3:0] S_C2    = 4'd6;
  localparam logic [3:0] S_EX    = 4'd7;
  localparam logic [3:0] S_M1    = 4'd8;
  localparam logic [3:0] S_M2    = 4'd9;
  localparam logic [3:0] S_M3    = 4'd10;
  localparam logic [3:0] S_M4    = 4'd11;
  localparam logic [3:0] S_M5    = 4'd12;
  localparam logic [3:0] S_FIN   = 4'd13;

  localparam int CNT_W = $clog2(DIV_W + 1);

  // configuration and persistent state
  logic [ST_W-1:0]         smooth_time;
  logic [THR_W-1:0]        low_threshold;
  logic [LVL_W-1:0]        trailing;
  logic signed [VEL_W-1:0] vel;
  logic                    was_low;

  // per-request registers
  logic [3:0]       state;
  logic             run;
  logic [LVL_W-1:0] tgt;
  logic [LVL_W-1:0] cur;
  logic [DT_W-1:0]  dt;
  logic [ST_W-1:0]  st_eff;
  logic             low;
  logic             changed;
  logic [31:0]      omega;
  logic [32:0]      x;
  logic [32:0]      x2;
  logic [40:0]      x3;
  logic [DEN_W-1:0] dsum;
  logic [16:0]      ex;
  val_t             change;
  val_t             sum1;
  val_t             temp;
  val_t             sum2;
  val_t             nv;

  // shared serial unit
  logic [PROD_W-1:0] mc;
  logic [PROD_W-1:0] acc;
  logic [MR_W-1:0]   mr;
  logic              neg;
  logic [DIV_W-1:0]  num;
  logic [DEN_W-1:0]  den;
  logic [DEN_W-1:0]  rem;
  logic [DIV_W-1:0]  quo;
  logic [CNT_W-1:0]  cnt;

  // unit operand selection per step
  logic              op_div;
  logic [MAG_W-1:0]  op_a;
  logic [MR_W-1:0]   op_b;
  logic              op_neg;
  logic [DIV_W-1:0]  op_num;
  logic [DEN_W-1:0]  op_den;
  val_t              ct_sum;

  assign ct_sum = change + temp;

  always_comb begin
    op_div = 1'b0;
    op_a   = '0;
    op_b   = '0;
    op_neg = 1'b0;
    op_num = '0;
    op_den = '0;
    unique case (state)
      S_OMEGA: begin
        op_div = 1'b1;
        op_num = DIV_W'(1) << (2 * FRAC_BITS + 1);
        op_den = DEN_W'(st_eff);
      end
      S_X: begin
        op_a = MAG_W'(omega);
        op_b = MR_W'(dt);
      end
      S_X2: begin
        op_a = MAG_W'(x);
        op_b = x[MR_W-1:0];
      end
      S_X3: begin
        op_a = MAG_W'(x2);
        op_b = x[MR_W-1:0];
      end
      S_C1: begin
        op_a = MAG_W'(x2);
        op_b = C048;
      end
      S_C2: begin
        op_a = MAG_W'(x3);
        op_b = C0235;
      end
      S_EX: begin
        op_div = 1'b1;
        op_num = DIV_W'(1) << (2 * FRAC_BITS);
        op_den = dsum;
      end
      S_M1: begin
        op_a   = MAG_W'(omega);
        op_b   = MR_W'(mag(change));
        op_neg = change[VAL_W-1];
      end
      S_M2: begin
        op_a   = mag(sum1);
        op_b   = MR_W'(dt);
        op_neg = sum1[VAL_W-1];
      end
      S_M3: begin
        op_a   = mag(temp);
        op_b   = omega;
        op_neg = temp[VAL_W-1];
      end
      S_M4: begin
        op_a   = mag(sum2);
        op_b   = MR_W'(ex);
        op_neg = sum2[VAL_W-1];
      end
      S_M5: begin
        op_a   = mag(ct_sum);
        op_b   = MR_W'(ex);
        op_neg = ct_sum[VAL_W-1];
      end
      default: ;
    endcase
  end

  // unit results and done
  logic [MAG_W-1:0] mul_mag;
  val_t             mul_res;
  logic [DEN_W:0]   div_shift;
  logic             div_ge;
  logic             unit_done;

  assign mul_mag   = acc[FRAC_BITS +: MAG_W];
  assign mul_res   = neg ? -val_t'({1'b0, mul_mag}) : val_t'({1'b0, mul_mag});
  assign div_shift = {rem, num[DIV_W-1]};
  assign div_ge    = div_shift >= {1'b0, den};
  assign unit_done = op_div ? (cnt == CNT_W'(DIV_W)) : (mr == '0);

  // input clamp and flag
  logic [LVL_W-1:0] lvl_c;
  logic             low_now;

  assign lvl_c   = (tick.level > ONE) ? ONE : tick.level;
  assign low_now = lvl_c <= low_threshold;

  // change clamped to twice the smoothing time
  val_t diff;
  val_t maxc;

  assign diff = val_t'(trailing) - val_t'(tgt);
  assign maxc = val_t'({st_eff, 1'b0});

  // final combine: output and overshoot; saturation follows in the last multiply state
  val_t outv;
  val_t out_fin;
  val_t nv_fin;
  logic overshoot;

  assign outv      = val_t'(cur) - change + mul_res;
  assign overshoot = (tgt > cur) == (outv > val_t'(tgt));
  assign out_fin   = overshoot ? val_t'(tgt) : outv;
  assign nv_fin    = overshoot ? '0 : nv;

  assign tick.ready = (state == S_IDLE);

  // configuration writes
  always_ff @(posedge clk) begin
    if (rst) begin
      smooth_time   <= ST_W'(13107);
      low_threshold <= THR_W'(19661);
    end else if (cfg_write_en) begin
      unique case (cfg_index)
        REG_SMOOTH_TIME:   smooth_time   <= cfg_data[ST_W-1:0];
        REG_LOW_THRESHOLD: low_threshold <= cfg_data[THR_W-1:0];
        default: ;
      endcase
    end
  end

  // sequencer and shared unit
  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_IDLE;
      run          <= 1'b0;
      trailing     <= '0;
      vel          <= '0;
      was_low      <= 1'b0;
      smooth.valid <= 1'b0;
    end else begin
      // result taken; the final state loads the next one itself
      if (smooth.valid && smooth.ready && (state != S_FIN)) begin
        smooth.valid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (tick.valid) begin
            tgt     <= lvl_c;
            cur     <= trailing;
            dt      <= tick.tick_time;
            st_eff  <= (smooth_time < EPS_T) ? EPS_T : smooth_time;
            low     <= low_now;
            changed <= low_now != was_low;
            was_low <= low_now;
            run     <= 1'b0;
            if (tick.tick_time == '0) begin
              state <= S_FIN;
            end else if (smooth_time == '0) begin
              trailing <= lvl_c;
              vel      <= '0;
              state    <= S_FIN;
            end else begin
              state <= S_OMEGA;
            end
          end
        end
        S_FIN: begin
          if (!smooth.valid || smooth.ready) begin
            smooth.valid          <= 1'b1;
            smooth.smoothed_level <= trailing;
            smooth.low_flag       <= low;
            smooth.low_changed    <= changed;
            state                 <= S_IDLE;
          end
        end
        default: begin
          if (!run) begin
            // load the unit
            run <= 1'b1;
            mc  <= PROD_W'(op_a);
            mr  <= op_b;
            acc <= '0;
            neg <= op_neg;
            num <= op_num;
            den <= op_den;
            rem <= '0;
            quo <= '0;
            cnt <= '0;
            if (state == S_OMEGA) begin
              change <= (diff > maxc) ? maxc : ((diff < -maxc) ? -maxc : diff);
            end
          end else if (!unit_done) begin
            // one step: shift-add or restoring subtract
            if (op_div) begin
              num <= num << 1;
              cnt <= cnt + CNT_W'(1);
              if (div_ge) begin
                rem <= DEN_W'(div_shift - {1'b0, den});
                quo <= {quo[DIV_W-2:0], 1'b1};
              end else begin
                rem <= div_shift[DEN_W-1:0];
                quo <= {quo[DIV_W-2:0], 1'b0};
              end
            end else begin
              if (mr[0]) begin
                acc <= acc + mc;
              end
              mc <= mc << 1;
              mr <= mr >> 1;
            end
          end else begin
            run <= 1'b0;
            unique case (state)
              S_OMEGA: begin
                omega <= quo[31:0];
                state <= S_X;
              end
              S_X: begin
                x <= mul_res[32:0];
                if (mul_res[32:0] > XCAP) begin
                  ex    <= '0;
                  state <= S_M1;
                end else begin
                  state <= S_X2;
                end
              end
              S_X2: begin
                x2    <= mul_res[32:0];
                state <= S_X3;
              end
              S_X3: begin
                x3    <= mul_res[40:0];
                state <= S_C1;
              end
              S_C1: begin
                dsum  <= DEN_W'(ONE) + DEN_W'(x) + mul_res[DEN_W-1:0];
                state <= S_C2;
              end
              S_C2: begin
                dsum  <= dsum + mul_res[DEN_W-1:0];
                state <= S_EX;
              end
              S_EX: begin
                ex    <= quo[16:0];
                state <= S_M1;
              end
              S_M1: begin
                sum1  <= val_t'(vel) + mul_res;
                state <= S_M2;
              end
              S_M2: begin
                temp  <= mul_res;
                state <= S_M3;
              end
              S_M3: begin
                sum2  <= val_t'(vel) - mul_res;
                state <= S_M4;
              end
              S_M4: begin
                nv    <= mul_res;
                state <= S_M5;
              end
              S_M5: begin
                // saturate velocity to 32 bits and value to 0..1
                if (nv_fin > val_t'(32'sh7FFFFFFF)) begin
                  vel <= 32'sh7FFFFFFF;
                end else if (nv_fin < -val_t'(33'sh080000000)) begin
                  vel <= 32'sh80000000;
                end else begin
                  vel <= nv_fin[VEL_W-1:0];
                end
                if (out_fin < 0) begin
                  trailing <= '0;
                end else if (out_fin > val_t'(ONE)) begin
                  trailing <= ONE;
                end else begin
                  trailing <= out_fin[LVL_W-1:0];
                end
                state <= S_FIN;
              end
              default: state <= S_IDLE;
            endcase
          end
        end
      endcase
    end
  end

endmodule

/* tb/tb_top.sv */
`timescale 1ns / 1ps
// tb_top: randomized check of the critically damped level smoother against
// an in-bench fixed-point predictor; depends on cds_pkg, cds_if and the dut
module tb_top;
  import cds_pkg::*;

  typedef struct packed {
    logic [LVL_W-1:0] smoothed_level;
    logic             low_flag;
    logic             low_changed;
  } smooth_res_t;

  localparam longint unsigned Q1      = 64'd1 << FRAC_BITS;
  localparam longint unsigned SAT_CAP = 64'd1 << 60;
  localparam longint          VEL_MAX = 64'sd2147483647;
  localparam longint          VEL_MIN = -64'sd2147483648;
  localparam longint unsigned CYCLE_LIMIT = 64'd3_000_000;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic             cfg_write_en = 1'b0;
  logic             cfg_index = REG_SMOOTH_TIME;
  logic [CFG_W-1:0] cfg_data = '0;

  cds_tick_if   tick ();
  cds_result_if smooth ();

  critically_damped_smoother dut (
    .clk(clk), .rst(rst), .cfg_write_en(cfg_write_en), .cfg_index(cfg_index),
    .cfg_data(cfg_data), .tick(tick.sink), .smooth(smooth.source)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // predictor state
  longint unsigned pr_smooth_time;
  longint unsigned pr_threshold;
  longint          pr_value;
  longint          pr_velocity;
  bit              pr_was_low;

  smooth_res_t expected_q[$];
  int  err_count = 0;
  int  results_seen = 0;
  int  ticks_sent = 0;
  longint unsigned cycle_count = 0;
  bit  long_stalls = 1'b1;

  // (a*b) >> FRAC_BITS, saturated
  function automatic longint unsigned fx_mul(longint unsigned a, longint unsigned b);
    logic [127:0] p;
    p = (128'(a) * 128'(b)) >> FRAC_BITS;
    return (p > 128'(SAT_CAP)) ? SAT_CAP : longint'(p[63:0]);
  endfunction

  function automatic longint fx_smul(longint a, longint b);
    longint r;
    r = longint'(fx_mul(a < 0 ? -a : a, b < 0 ? -b : b));
    return ((a < 0) != (b < 0)) ? -r : r;
  endfunction

  function automatic longint clamp(longint v, longint lo, longint hi);
    return v < lo ? lo : (v > hi ? hi : v);
  endfunction

  function automatic longint clamp_cap(longint v);
    return clamp(v, -longint'(SAT_CAP), longint'(SAT_CAP));
  endfunction

  // one spring step of the trailing value toward tgt
  task automatic spring_step(longint tgt, longint unsigned dt);
    longint unsigned st, omega, x, x2, x3, den, ex;
    longint cur, change, maxc, t2, temp, nv, outv;
    st = pr_smooth_time < EPS_T ? EPS_T : pr_smooth_time;
    omega = (2 * Q1 * Q1) / st;
    x = fx_mul(omega, dt);
    ex = 0;
    if (x <= XCAP) begin
      x2 = fx_mul(x, x);
      x3 = fx_mul(x2, x);
      den = Q1 + x + fx_mul(C048, x2) + fx_mul(C0235, x3);
      ex = (Q1 << FRAC_BITS) / den;
    end
    cur = pr_value;
    maxc = longint'(2 * st);
    change = clamp(cur - tgt, -maxc, maxc);
    t2 = cur - change;
    temp = fx_smul(clamp_cap(pr_velocity + fx_smul(omega, change)), dt);
    nv = fx_smul(clamp_cap(pr_velocity - fx_smul(omega, temp)), ex);
    outv = clamp_cap(t2 + fx_smul(clamp_cap(change + temp), ex));
    if ((tgt - cur > 0) == (outv > tgt)) begin
      outv = tgt;
      nv = 0;
    end
    pr_velocity = clamp(nv, VEL_MIN, VEL_MAX);
    pr_value = clamp(outv, 0, longint'(Q1));
  endtask

  // expected result of one tick request
  task automatic predict_smoothing(logic [LVL_W-1:0] lvl_in, logic [DT_W-1:0] dt);
    longint unsigned lvl;
    bit low;
    smooth_res_t r;
    lvl = lvl_in > Q1 ? Q1 : lvl_in;
    low = lvl <= pr_threshold;
    r.low_changed = low != pr_was_low;
    r.low_flag = low;
    pr_was_low = low;
    if (dt != 0) begin
      if (pr_smooth_time == 0) begin
        pr_value = longint'(lvl);
        pr_velocity = 0;
      end else begin
        spring_step(longint'(lvl), dt);
      end
    end
    r.smoothed_level = pr_value[LVL_W-1:0];
    expected_q.push_back(r);
  endtask

  function automatic int gap_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 40) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return long_stalls ? $urandom_range(8, 40) : 1;
  endfunction

  // send one tick request and predict its result
  task automatic send_tick(logic [LVL_W-1:0] lvl, logic [DT_W-1:0] dt);
    int g;
    g = gap_len();
    if (g > 0) begin
      tick.valid <= 1'b0;
      repeat (g) @(posedge clk);
    end
    tick.valid <= 1'b1;
    tick.level <= lvl;
    tick.tick_time <= dt;
    @(posedge clk);
    while (!tick.ready) @(posedge clk);
    predict_smoothing(lvl, dt);
    ticks_sent++;
  endtask

  task automatic drain();
    tick.valid <= 1'b0;
    while (expected_q.size() != 0) @(posedge clk);
    repeat (400) @(posedge clk);
  endtask

  task automatic write_reg(logic idx, logic [CFG_W-1:0] val);
    cfg_write_en <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    cfg_write_en <= 1'b0;
    @(posedge clk);
    if (idx == REG_SMOOTH_TIME) pr_smooth_time = val;
    else pr_threshold = val[THR_W-1:0];
  endtask

  // ready with random stalls
  initial begin
    smooth.ready = 1'b0;
    @(negedge rst);
    forever begin
      @(posedge clk);
      if ($urandom_range(0, 2) == 0) smooth.ready <= 1'b0;
      else if (long_stalls && $urandom_range(0, 30) == 0) begin
        smooth.ready <= 1'b0;
        repeat ($urandom_range(5, 30)) @(posedge clk);
        smooth.ready <= 1'b1;
      end else smooth.ready <= 1'b1;
    end
  end

  // compare each result with the oldest expectation
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (!rst && smooth.valid && smooth.ready) begin
      if (expected_q.size() == 0) begin
        $error("unexpected result smoothed_level=%0d", smooth.smoothed_level);
        err_count++;
      end else begin
        smooth_res_t e;
        e = expected_q.pop_front();
        results_seen++;
        if (smooth.smoothed_level !== e.smoothed_level) begin
          $error("smoothed_level expected %0d got %0d", e.smoothed_level,
                 smooth.smoothed_level);
          err_count++;
        end
        if (smooth.low_flag !== e.low_flag) begin
          $error("low_flag expected %0d got %0d", e.low_flag, smooth.low_flag);
          err_count++;
        end
        if (smooth.low_changed !== e.low_changed) begin
          $error("low_changed expected %0d got %0d", e.low_changed, smooth.low_changed);
          err_count++;
        end
      end
    end
    if (cycle_count > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycle_count);
      $display("FAILURE");
      $finish;
    end
  end

  // extremes, threshold edges, zero tick time, above-one level
  task automatic test_directed();
    send_tick(17'd0, 16'd0);
    send_tick(17'd65536, 16'd6554);
    send_tick(17'h1FFFF, 16'd65535);
    send_tick(17'd19661, 16'd1000);
    send_tick(17'd19662, 16'd1000);
    send_tick(17'd0, 16'd1);
    send_tick(17'd40000, 16'd0);
    send_tick(17'd70000, 16'd300);
    send_tick(17'd100, 16'hAAAA);
    send_tick(17'd65535, 16'h5555);
    send_tick(17'd0, 16'd65535);
  endtask

  // snap behavior at zero smoothing time
  task automatic test_snap();
    write_reg(REG_SMOOTH_TIME, 20'd0);
    write_reg(REG_LOW_THRESHOLD, 20'd0);
    send_tick(17'd50000, 16'd10);
    send_tick(17'd0, 16'd10);
    send_tick(17'h1FFFF, 16'd0);
    send_tick(17'h1FFFF, 16'd1);
    drain();
  endtask

  // tiny and huge smoothing times, threshold extremes
  task automatic test_extreme_settings();
    write_reg(REG_SMOOTH_TIME, 20'd1);
    write_reg(REG_LOW_THRESHOLD, 20'd65536);
    send_tick(17'd0, 16'd65535);
    send_tick(17'd65536, 16'd1);
    send_tick(17'd30000, 16'd200);
    drain();
    write_reg(REG_SMOOTH_TIME, 20'hFFFFF);
    write_reg(REG_LOW_THRESHOLD, 20'h1FFFF);
    send_tick(17'd65536, 16'd65535);
    send_tick(17'd0, 16'd3);
    send_tick(17'd65536, 16'd40000);
    drain();
  endtask

  // random ticks in phases with different register settings
  task automatic test_random(int n_phases, int per_phase);
    int r;
    logic [LVL_W-1:0] lvl;
    logic [DT_W-1:0] dt;
    for (int p = 0; p < n_phases; p++) begin
      long_stalls = (p % 3) != 2;
      case ($urandom_range(0, 4))
        0: write_reg(REG_SMOOTH_TIME, CFG_W'($urandom_range(0, 8)));
        1: write_reg(REG_SMOOTH_TIME, CFG_W'($urandom_range(500, 40000)));
        2: write_reg(REG_SMOOTH_TIME, CFG_W'($urandom_range(0, 655360)));
        3: write_reg(REG_SMOOTH_TIME, CFG_W'($urandom_range(0, 20'hFFFFF)));
        default: write_reg(REG_SMOOTH_TIME, 20'd13107);
      endcase
      write_reg(REG_LOW_THRESHOLD, CFG_W'($urandom_range(0, 3) == 0 ?
                $urandom_range(0, 17'h1FFFF) : $urandom_range(0, 65536)));
      for (int i = 0; i < per_phase; i++) begin
        r = $urandom_range(0, 9);
        lvl = (r == 0) ? LVL_W'($urandom_range(0, 17'h1FFFF)) :
              (r == 1) ? pr_threshold[LVL_W-1:0] : LVL_W'($urandom_range(0, 65536));
        r = $urandom_range(0, 9);
        dt = (r == 0) ? 16'd0 : (r < 3) ? DT_W'($urandom_range(0, 16'hFFFF)) :
             DT_W'($urandom_range(1, 3000));
        send_tick(lvl, dt);
      end
      drain();
    end
  endtask

  initial begin
    tick.valid = 1'b0;
    tick.level = '0;
    tick.tick_time = '0;
    pr_smooth_time = 13107;
    pr_threshold = 19661;
    pr_value = 0;
    pr_velocity = 0;
    pr_was_low = 1'b0;
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_directed();
    drain();
    test_snap();
    test_extreme_settings();
    test_random(18, 100);
    drain();
    $display("covered %0d tick requests and %0d results over several register settings",
             ticks_sent, results_seen);
    if (err_count == 0 && expected_q.size() == 0) $display("SUCCESS");
    else $display("FAILURE");
    $finish;
  end
endmodule
